FILE: hw/rtl/stable_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// stable_priority_queue_defines
// assertion macros shared by the priority queue modules
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// command and status types shared by the queue controller and datapath
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef struct packed {
		logic step;          // a request is taken this cycle
		logic do_insert;     // insert into a queue with room
		logic do_remove;     // pop from a non-empty queue
		logic drop_insert;   // insert into a full queue
		logic empty_remove;  // pop from an empty queue
	} spq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} spq_status_t;

endpackage

FILE: hw/rtl/stable_priority_queue.sv
// latency: a result is ready the cycle after its request is taken
// throughput: one request per cycle unless out_ready stalls a held result;
// cells compare, shift in one step; a request goes in as the held result goes out
// reset: async active low, clears cell valid bits, the count and the handshake
// state; cell contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue, higher priority first, equal priorities in arrival order
// ----------------------------------------------------------------------------
module stable_priority_queue #(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [7:0]                    prio_in,
	input  logic [15:0]                   tag_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          removed_valid,
	output logic [7:0]                    removed_prio,
	output logic [15:0]                   removed_tag,
	output logic                          head_valid,
	output logic [7:0]                    head_prio,
	output logic [15:0]                   head_tag,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                          overflow,
	output logic                          underflow
);

	spq_pkg::spq_cmd_t    cmd;
	spq_pkg::spq_status_t status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	spq_dpath #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.prio_in       (prio_in),
		.tag_in        (tag_in),
		.status        (status),
		.removed_valid (removed_valid),
		.removed_prio  (removed_prio),
		.removed_tag   (removed_tag),
		.head_valid    (head_valid),
		.head_prio     (head_prio),
		.head_tag      (head_tag),
		.entry_count   (entry_count),
		.overflow      (overflow),
		.underflow     (underflow)
	);

endmodule

FILE: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: takes requests, decodes them against queue status
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  spq_pkg::spq_status_t status,
	output spq_pkg::spq_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	// a pending result that is taken this cycle frees the output register
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_HOLD);

	always_comb begin
		cmd              = '0;
		cmd.step         = accept;
		cmd.do_insert    = accept && (func == spq_pkg::FUNC_INSERT) && !status.full;
		cmd.drop_insert  = accept && (func == spq_pkg::FUNC_INSERT) && status.full;
		cmd.do_remove    = accept && (func == spq_pkg::FUNC_REMOVE) && !status.empty;
		cmd.empty_remove = accept && (func == spq_pkg::FUNC_REMOVE) && status.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (!accept && out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SPQ_ASSERT_SAME(a_stall_blocks, out_valid && !out_ready, !in_ready, "request taken over stalled result")
	`SPQ_ASSERT_NEXT(a_accept_shows, accept, out_valid, "accepted request gave no result")
	`SPQ_ASSERT_SAME(a_drop_full, cmd.drop_insert || cmd.do_insert, status.full == cmd.drop_insert, "insert decode disagrees with full")

endmodule

FILE: hw/rtl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// sorted cell chain: every cell compares the new entry and shifts in parallel
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_dpath #(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spq_pkg::spq_cmd_t                  cmd,
	input  logic [7:0]                         prio_in,
	input  logic [15:0]                        tag_in,
	output spq_pkg::spq_status_t               status,
	output logic                               removed_valid,
	output logic [7:0]                         removed_prio,
	output logic [15:0]                        removed_tag,
	output logic                               head_valid,
	output logic [7:0]                         head_prio,
	output logic [15:0]                        head_tag,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
	output logic                               overflow,
	output logic                               underflow
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [7:0]          prio_q [CAPACITY];
	logic [TAG_BITS-1:0] tag_q  [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CW-1:0]       count_q;

	logic [7:0]          prio_d [CAPACITY];
	logic [TAG_BITS-1:0] tag_d  [CAPACITY];
	logic [CAPACITY-1:0] valid_d;
	logic [CW-1:0]       count_d;

	logic [CAPACITY-1:0] stay;
	logic [TAG_BITS+15:0] new_tag_ext;
	logic [TAG_BITS-1:0]  new_tag;
	logic [TAG_BITS+15:0] rem_tag_ext;
	logic [TAG_BITS+15:0] head_tag_ext;

	assign new_tag_ext  = {{TAG_BITS{1'b0}}, tag_in};
	assign new_tag      = new_tag_ext[TAG_BITS-1:0];
	assign rem_tag_ext  = {16'd0, tag_q[0]};
	assign head_tag_ext = {16'd0, tag_d[0]};

	assign status.full  = (count_q == CW'(CAPACITY));
	assign status.empty = (count_q == '0);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [7:0]          up_prio;
		logic [TAG_BITS-1:0] up_tag;
		logic                up_valid;
		logic                up_stay;
		logic [7:0]          dn_prio;
		logic [TAG_BITS-1:0] dn_tag;
		logic                dn_valid;
		logic [7:0]          nxt_prio;
		logic [TAG_BITS-1:0] nxt_tag;
		logic                nxt_valid;

		// held entries of equal or higher priority stay ahead of the new one
		assign stay[g] = valid_q[g] && (prio_q[g] >= prio_in);

		if (g == 0) begin : g_first
			assign up_prio  = prio_q[g];
			assign up_tag   = tag_q[g];
			assign up_valid = valid_q[g];
			assign up_stay  = 1'b1;
		end else begin : g_rest
			assign up_prio  = prio_q[g-1];
			assign up_tag   = tag_q[g-1];
			assign up_valid = valid_q[g-1];
			assign up_stay  = stay[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign dn_prio  = prio_q[g];
			assign dn_tag   = tag_q[g];
			assign dn_valid = 1'b0;
		end else begin : g_mid
			assign dn_prio  = prio_q[g+1];
			assign dn_tag   = tag_q[g+1];
			assign dn_valid = valid_q[g+1];
		end

		always_comb begin
			nxt_prio  = prio_q[g];
			nxt_tag   = tag_q[g];
			nxt_valid = valid_q[g];
			if (cmd.do_insert && !stay[g]) begin
				if (up_stay) begin
					nxt_prio  = prio_in;
					nxt_tag   = new_tag;
					nxt_valid = 1'b1;
				end else begin
					nxt_prio  = up_prio;
					nxt_tag   = up_tag;
					nxt_valid = up_valid;
				end
			end else if (cmd.do_remove) begin
				nxt_prio  = dn_prio;
				nxt_tag   = dn_tag;
				nxt_valid = dn_valid;
			end
		end

		assign prio_d[g]  = nxt_prio;
		assign tag_d[g]   = nxt_tag;
		assign valid_d[g] = nxt_valid;
	end

	always_comb begin
		count_d = count_q;
		if (cmd.do_insert) begin
			count_d = count_q + 1'b1;
		end else if (cmd.do_remove) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.step) begin
			valid_q <= valid_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_insert || cmd.do_remove) begin
			prio_q <= prio_d;
			tag_q  <= tag_d;
		end
	end

	// result register, loaded with every request
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			removed_valid <= cmd.do_remove;
			removed_prio  <= cmd.do_remove ? prio_q[0] : 8'd0;
			removed_tag   <= cmd.do_remove ? rem_tag_ext[15:0] : 16'd0;
			head_valid    <= valid_d[0];
			head_prio     <= valid_d[0] ? prio_d[0] : 8'd0;
			head_tag      <= valid_d[0] ? head_tag_ext[15:0] : 16'd0;
			entry_count   <= count_d;
			overflow      <= cmd.drop_insert;
			underflow     <= cmd.empty_remove;
		end
	end

	`SPQ_ASSERT_SAME(a_count_match, 1'b1, $countones(valid_q) == int'(count_q), "count differs from valid cells")
	`SPQ_ASSERT_SAME(a_valid_prefix, 1'b1, (valid_q & (valid_q + 1'b1)) == '0, "valid cells not packed at head")
	`SPQ_ASSERT_NEXT(a_insert_grows, cmd.do_insert, count_q == $past(count_q) + 1'b1, "insert did not grow count")

endmodule
